>>> src/lsu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the literal string unescaper.
// No dependencies; imported by lsu_decoder and literal_string_unescape.
package lsu_pkg;

  // Default bound on parenthesis nesting
  localparam int unsigned MaxNestingDef = 255;

  // Characters with a meaning of their own
  localparam logic [7:0] ChOpen      = 8'h28;  // (
  localparam logic [7:0] ChClose     = 8'h29;  // )
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_CR   = 3'd3,
    MODE_OCT  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2
  } status_e;

  // Everything one raw byte decodes to
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [1:0] n_bytes;
    status_e    status;
  } dec_out_t;

endpackage

>>> src/lsu_decoder.sv
`timescale 1ns / 1ps
// Decode state and per-byte decode logic of the literal string unescaper.
// Depends on lsu_pkg.
module lsu_decoder
  import lsu_pkg::*;
#(
  parameter int unsigned MAX_NESTING = MaxNestingDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] data_i,
  input  logic       eod_i,
  output dec_out_t   dec_o
);

  localparam int unsigned DepthW = $clog2(MAX_NESTING + 1);

  typedef struct packed {
    mode_e             mode;
    logic [DepthW-1:0] depth;
    logic              emit;
    logic [7:0]        ch;
    status_e           status;
  } str_res_t;

  mode_e             mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [8:0]        acc_q, acc_d;
  logic [1:0]        digits_q, digits_d;

  // Plain string byte: nesting, end of string, start of escape
  function automatic str_res_t str_step(input logic [7:0] c, input logic [DepthW-1:0] d);
    str_res_t r;
    r.mode   = MODE_STR;
    r.depth  = d;
    r.emit   = 1'b0;
    r.ch     = c;
    r.status = ST_PROGRESS;
    if (c == ChOpen) begin
      if (d >= DepthW'(MAX_NESTING)) begin
        r.mode   = MODE_IDLE;
        r.depth  = '0;
        r.status = ST_ERROR;
      end else begin
        r.depth = d + 1'b1;
        r.emit  = 1'b1;
      end
    end else if (c == ChClose) begin
      if (d <= DepthW'(1)) begin
        r.mode   = MODE_IDLE;
        r.depth  = '0;
        r.status = ST_COMPLETE;
      end else begin
        r.depth = d - 1'b1;
        r.emit  = 1'b1;
      end
    end else if (c == ChBackslash) begin
      r.mode = MODE_ESC;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  // Decode one byte against the current state
  always_comb begin
    str_res_t   sr;
    logic       oct;
    logic [8:0] acc_n;
    mode_d          = mode_q;
    depth_d         = depth_q;
    acc_d           = acc_q;
    digits_d        = digits_q;
    dec_o.byte0     = 8'h00;
    dec_o.byte1     = 8'h00;
    dec_o.n_bytes   = 2'd0;
    dec_o.status    = ST_PROGRESS;
    oct             = (data_i inside {[ChZero:ChSeven]});
    acc_n           = {acc_q[5:0], data_i[2:0]};
    sr              = str_step(data_i, depth_q);

    case (mode_q)
      MODE_IDLE: begin
        acc_d    = '0;
        digits_d = '0;
        if (data_i == ChOpen) begin
          depth_d = DepthW'(1);
          mode_d  = MODE_STR;
        end else begin
          depth_d      = '0;
          dec_o.status = ST_ERROR;
        end
      end
      MODE_ESC: begin
        mode_d        = MODE_STR;
        dec_o.n_bytes = 2'd1;
        case (data_i)
          ChLowerN: dec_o.byte0 = ChLf;
          ChLowerR: dec_o.byte0 = ChCr;
          ChLowerT: dec_o.byte0 = ChTab;
          ChLowerB: dec_o.byte0 = ChBs;
          ChLowerF: dec_o.byte0 = ChFf;
          ChCr: begin
            mode_d        = MODE_CR;
            dec_o.n_bytes = 2'd0;
          end
          ChLf: dec_o.n_bytes = 2'd0;
          default: begin
            if (oct) begin
              acc_d         = {6'd0, data_i[2:0]};
              digits_d      = 2'd1;
              mode_d        = MODE_OCT;
              dec_o.n_bytes = 2'd0;
            end else begin
              dec_o.byte0 = data_i;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (oct) begin
          if (digits_q >= 2'd2) begin
            // third digit: emit at once
            dec_o.byte0   = acc_n[7:0];
            dec_o.n_bytes = 2'd1;
            acc_d         = '0;
            digits_d      = '0;
            mode_d        = MODE_STR;
          end else begin
            acc_d    = acc_n;
            digits_d = digits_q + 2'd1;
          end
        end else begin
          // flush the pending octal byte, then decode this one as plain
          dec_o.byte0   = acc_q[7:0];
          dec_o.byte1   = sr.ch;
          dec_o.n_bytes = sr.emit ? 2'd2 : 2'd1;
          acc_d         = '0;
          digits_d      = '0;
          mode_d        = sr.mode;
          depth_d       = sr.depth;
          dec_o.status  = sr.status;
        end
      end
      MODE_CR: begin
        if (data_i == ChLf) begin
          mode_d = MODE_STR;
        end else begin
          dec_o.byte0   = sr.ch;
          dec_o.n_bytes = {1'b0, sr.emit};
          mode_d        = sr.mode;
          depth_d       = sr.depth;
          dec_o.status  = sr.status;
        end
      end
      default: begin
        dec_o.byte0   = sr.ch;
        dec_o.n_bytes = {1'b0, sr.emit};
        mode_d        = sr.mode;
        depth_d       = sr.depth;
        dec_o.status  = sr.status;
      end
    endcase

    // Data ran out with the string still open
    if (eod_i && dec_o.status == ST_PROGRESS && mode_d != MODE_IDLE) begin
      dec_o.status = ST_ERROR;
      mode_d       = MODE_IDLE;
    end
    if (mode_d == MODE_IDLE) begin
      depth_d  = '0;
      acc_d    = '0;
      digits_d = '0;
    end
  end

  // Advance the decode state on every byte handed to the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      depth_q  <= '0;
      acc_q    <= '0;
      digits_q <= '0;
    end else if (adv_i) begin
      mode_q   <= mode_d;
      depth_q  <= depth_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
    end
  end

endmodule

>>> src/literal_string_unescape.sv
`timescale 1ns / 1ps
// Top level of the literal string unescaper: input register, result buffer.
// Depends on lsu_pkg and lsu_decoder.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one raw byte and an
//   end-of-data flag per transfer. Output channel (out_valid_o / out_ready_i)
//   carries one result per transfer: a decoded byte with byte_valid_o, the
//   status (in progress, complete, error) and last_of_run_o on the final
//   result of each input byte. Each input byte gives one or two results.
//   Path: a byte accepted into the input register is decoded into the result
//   buffer once the buffer is free, and its first result is offered from there.
//   Throughput: one input byte per cycle while each gives a single result and
//   out_ready_i stays high; a byte that gives two results holds the result
//   buffer until both are taken, as the output port completes one per cycle.
//   Stall: when out_ready_i is low the result buffer holds, the input
//   register fills behind it and in_ready_o drops; nothing is lost.
//   Reset: the decoder returns to idle (awaiting an opening parenthesis)
//   with zero nesting depth; both registers are emptied.
module literal_string_unescape
  import lsu_pkg::*;
#(
  parameter int unsigned MAX_NESTING = MaxNestingDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic       last_of_run_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eod_q;
  logic       buf_valid_q;
  logic       buf_sel_q;
  dec_out_t   buf_q;
  dec_out_t   dec;
  logic       buf_two, buf_pop, buf_free, s1_adv, in_xfer;

  lsu_decoder #(
    .MAX_NESTING(MAX_NESTING)
  ) u_decoder (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (s1_adv),
    .data_i(s1_byte_q),
    .eod_i (s1_eod_q),
    .dec_o (dec)
  );

  // Handshake between input register and result buffer
  assign buf_two    = (buf_q.n_bytes == 2'd2);
  assign buf_pop    = buf_valid_q && out_ready_i && (!buf_two || buf_sel_q);
  assign buf_free   = !buf_valid_q || buf_pop;
  assign s1_adv     = s1_valid_q && buf_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= data_byte_i;
      s1_eod_q  <= end_of_data_i;
    end
  end

  // Result buffer: hold the decode, step through its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      buf_sel_q   <= 1'b0;
    end else if (buf_free) begin
      buf_valid_q <= s1_valid_q;
      buf_sel_q   <= 1'b0;
    end else if (buf_valid_q && out_ready_i) begin
      buf_sel_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      buf_q <= dec;
    end
  end

  // Drive the current result
  always_comb begin
    out_valid_o   = buf_valid_q;
    out_byte_o    = 8'h00;
    byte_valid_o  = 1'b0;
    status_o      = buf_q.status;
    last_of_run_o = 1'b1;
    if (buf_two && !buf_sel_q) begin
      out_byte_o    = buf_q.byte0;
      byte_valid_o  = 1'b1;
      status_o      = ST_PROGRESS;
      last_of_run_o = 1'b0;
    end else if (buf_two) begin
      out_byte_o   = buf_q.byte1;
      byte_valid_o = 1'b1;
    end else if (buf_q.n_bytes == 2'd1) begin
      out_byte_o   = buf_q.byte0;
      byte_valid_o = 1'b1;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for literal_string_unescape: directed and random byte streams.
// Depends on lsu_pkg and the RTL only; results are checked by a decoder model kept here.
module tb;
  import lsu_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // One expected or observed result
  typedef struct packed {
    logic [7:0] ob;
    logic       bv;
    status_e    st;
    logic       last;
  } dec_result_t;

  // One raw byte to send, with an optional hand-written single result
  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       typed;
    logic [7:0] ob;
    logic       bv;
    status_e    st;
  } stim_row_t;

  // Directed stream: refusal while idle, extreme bytes, nesting, escapes,
  // continuations, octal overflow, pending octal flush, completion, early end
  localparam stim_row_t DirectedRows [25] = '{
    '{8'h41,       1'b0, 1'b1, 8'h00,   1'b0, ST_ERROR},
    '{ChOpen,      1'b0, 1'b1, 8'h00,   1'b0, ST_PROGRESS},
    '{8'h00,       1'b0, 1'b1, 8'h00,   1'b1, ST_PROGRESS},
    '{8'hFF,       1'b0, 1'b1, 8'hFF,   1'b1, ST_PROGRESS},
    '{ChOpen,      1'b0, 1'b1, ChOpen,  1'b1, ST_PROGRESS},
    '{ChClose,     1'b0, 1'b1, ChClose, 1'b1, ST_PROGRESS},
    '{ChBackslash, 1'b0, 1'b1, 8'h00,   1'b0, ST_PROGRESS},
    '{ChLowerN,    1'b0, 1'b1, ChLf,    1'b1, ST_PROGRESS},
    '{ChBackslash, 1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{ChCr,        1'b0, 1'b1, 8'h00,   1'b0, ST_PROGRESS},
    '{ChLf,        1'b0, 1'b1, 8'h00,   1'b0, ST_PROGRESS},
    '{ChBackslash, 1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{ChLf,        1'b0, 1'b1, 8'h00,   1'b0, ST_PROGRESS},
    '{ChBackslash, 1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{8'h7A,       1'b0, 1'b1, 8'h7A,   1'b1, ST_PROGRESS},
    '{ChBackslash, 1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{ChSeven,     1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{ChSeven,     1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{ChSeven,     1'b0, 1'b1, 8'hFF,   1'b1, ST_PROGRESS},
    '{ChBackslash, 1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{8'h35,       1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{8'h41,       1'b0, 1'b0, 8'h00,   1'b0, ST_PROGRESS},
    '{ChClose,     1'b0, 1'b1, 8'h00,   1'b0, ST_COMPLETE},
    '{ChOpen,      1'b1, 1'b1, 8'h00,   1'b0, ST_ERROR},
    '{ChClose,     1'b0, 1'b1, 8'h00,   1'b0, ST_ERROR}
  };

  localparam logic [7:0] EscLetters [8] = '{
    ChLowerN, ChLowerR, ChLowerT, ChLowerB, ChLowerF, ChBackslash, ChOpen, ChClose
  };

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] data_byte_i   = 8'h00;
  logic       end_of_data_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic [1:0] status_o;
  logic       last_of_run_o;

  literal_string_unescape u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  // Decoder state as the block should hold it
  mode_e       dec_mode  = MODE_IDLE;
  int unsigned nest      = 0;
  logic [8:0]  oct_acc   = 9'd0;
  int unsigned oct_cnt   = 0;
  logic [7:0]  step_bytes [$];
  status_e     step_status;
  dec_result_t step_results [$];

  dec_result_t pending_results [$];
  stim_row_t   seq_q [$];
  int unsigned n_errors = 0;
  int unsigned cycles   = 0;
  bit          calm     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit is_octal(input logic [7:0] c);
    return c >= ChZero && c <= ChSeven;
  endfunction

  function automatic void back_to_idle(input status_e st);
    step_status = st;
    dec_mode    = MODE_IDLE;
    nest        = 0;
    oct_acc     = 9'd0;
    oct_cnt     = 0;
  endfunction

  // Plain string byte: track nesting, start escapes, pass the rest
  function automatic void string_byte(input logic [7:0] c);
    dec_mode = MODE_STR;
    if (c == ChOpen) begin
      if (nest >= MaxNestingDef) begin
        back_to_idle(ST_ERROR);
      end else begin
        nest++;
        step_bytes.push_back(ChOpen);
      end
    end else if (c == ChClose) begin
      if (nest > 0) nest--;
      if (nest == 0) back_to_idle(ST_COMPLETE);
      else step_bytes.push_back(ChClose);
    end else if (c == ChBackslash) begin
      dec_mode = MODE_ESC;
    end else begin
      step_bytes.push_back(c);
    end
  endfunction

  // Advance the decoder by one raw byte and build its results
  function automatic void unescape_byte(input logic [7:0] c, input logic eod);
    int unsigned n;
    step_bytes.delete();
    step_results.delete();
    step_status = ST_PROGRESS;
    case (dec_mode)
      MODE_IDLE: begin
        if (c == ChOpen) begin
          nest     = 1;
          dec_mode = MODE_STR;
          oct_acc  = 9'd0;
          oct_cnt  = 0;
        end else begin
          back_to_idle(ST_ERROR);
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_STR;
        case (c)
          ChLowerN: step_bytes.push_back(ChLf);
          ChLowerR: step_bytes.push_back(ChCr);
          ChLowerT: step_bytes.push_back(ChTab);
          ChLowerB: step_bytes.push_back(ChBs);
          ChLowerF: step_bytes.push_back(ChFf);
          ChCr:     dec_mode = MODE_CR;
          ChLf:     ;
          default: begin
            if (is_octal(c)) begin
              oct_acc  = {6'd0, c[2:0]};
              oct_cnt  = 1;
              dec_mode = MODE_OCT;
            end else begin
              step_bytes.push_back(c);
            end
          end
        endcase
      end
      MODE_CR: begin
        // swallow the LF of a CRLF continuation
        if (c == ChLf) dec_mode = MODE_STR;
        else string_byte(c);
      end
      MODE_OCT: begin
        if (is_octal(c)) begin
          oct_acc = {oct_acc[5:0], c[2:0]};
          oct_cnt++;
          if (oct_cnt >= 3) begin
            step_bytes.push_back(oct_acc[7:0]);
            oct_acc  = 9'd0;
            oct_cnt  = 0;
            dec_mode = MODE_STR;
          end
        end else begin
          // flush the pending octal byte, then decode this one normally
          step_bytes.push_back(oct_acc[7:0]);
          oct_acc = 9'd0;
          oct_cnt = 0;
          string_byte(c);
        end
      end
      default: string_byte(c);
    endcase

    if (eod && step_status == ST_PROGRESS && dec_mode != MODE_IDLE) back_to_idle(ST_ERROR);

    n = step_bytes.size();
    if (n == 0) begin
      step_results.push_back('{8'h00, 1'b0, step_status, 1'b1});
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        step_results.push_back('{step_bytes[k], 1'b1,
                                 (k == n - 1) ? step_status : ST_PROGRESS,
                                 (k == n - 1)});
      end
    end
  endfunction

  function automatic int unsigned draw_pause();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Send one byte, wait for its transfer, then queue what it should give
  task automatic transfer_byte(input stim_row_t r);
    int unsigned gap;
    gap = draw_pause();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= r.data;
    end_of_data_i <= r.eod;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    unescape_byte(r.data, r.eod);
    if (r.typed) begin
      pending_results.push_back('{r.ob, r.bv, r.st, 1'b1});
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // Hold the input side until every queued result has come out
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic eod);
    seq_q.push_back('{b, eod, 1'b0, 8'h00, 1'b0, ST_PROGRESS});
  endfunction

  // Build one random sequence: mostly well-formed strings, some cut short, some noise
  task automatic compose_sequence();
    int unsigned kind;
    int unsigned depth_gen;
    int unsigned cut;
    logic [7:0]  b;
    stim_row_t   r;
    seq_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      add_byte(ChOpen, 1'b0);
      depth_gen = 1;
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            b = 8'($urandom_range(0, 255));
            if (b == ChOpen || b == ChClose || b == ChBackslash) b ^= 8'h40;
            add_byte(b, 1'b0);
          end
          4: begin
            add_byte(ChOpen, 1'b0);
            depth_gen++;
          end
          5: begin
            if (depth_gen > 1) begin
              add_byte(ChClose, 1'b0);
              depth_gen--;
            end else begin
              add_byte(8'h78, 1'b0);
            end
          end
          6: begin
            add_byte(ChBackslash, 1'b0);
            add_byte(EscLetters[$urandom_range(0, 7)], 1'b0);
          end
          7: begin
            add_byte(ChBackslash, 1'b0);
            case ($urandom_range(0, 2))
              0: add_byte(ChCr, 1'b0);
              1: begin
                add_byte(ChCr, 1'b0);
                add_byte(ChLf, 1'b0);
              end
              default: add_byte(ChLf, 1'b0);
            endcase
          end
          8: begin
            add_byte(ChBackslash, 1'b0);
            repeat ($urandom_range(1, 3)) add_byte(ChZero + 8'($urandom_range(0, 7)), 1'b0);
          end
          default: begin
            add_byte(ChBackslash, 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b0);
          end
        endcase
      end
      repeat (depth_gen) add_byte(ChClose, 1'b0);
      // drop the tail so the string is still open at the end of data
      if (kind == 1) begin
        cut = $urandom_range(1, seq_q.size() - 1);
        while (seq_q.size() > cut) void'(seq_q.pop_back());
      end
    end
    // end of data on the last byte resynchronises noise and cut strings
    if (kind <= 1 || $urandom_range(0, 2) == 0) begin
      r = seq_q.pop_back();
      r.eod = 1'b1;
      seq_q.push_back(r);
    end
  endtask

  // Alternate stretches of random idling with stretches of none
  initial begin
    forever begin
      repeat (calm ? $urandom_range(20, 80) : $urandom_range(100, 400)) @(posedge clk_i);
      calm = ~calm;
    end
  end

  // Result side: random stall before each transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = draw_pause();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // Compare each result transfer with the oldest expectation; enforce the time limit
  always @(posedge clk_i) begin
    dec_result_t want;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("status: fail");
      $finish;
    end else if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (n_errors < 20) begin
          $display("%0t: unexpected result byte=%02h valid=%0b status=%0d last=%0b",
                   $time, out_byte_o, byte_valid_o, status_o, last_of_run_o);
        end
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_byte_o !== want.ob || byte_valid_o !== want.bv ||
            status_o !== want.st || last_of_run_o !== want.last) begin
          if (n_errors < 20) begin
            $display("%0t: mismatch expected byte=%02h valid=%0b status=%0d last=%0b, %s",
                     $time, want.ob, want.bv, want.st, want.last, "got below");
            $display("%0t:          actual   byte=%02h valid=%0b status=%0d last=%0b",
                     $time, out_byte_o, byte_valid_o, status_o, last_of_run_o);
          end
          n_errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, nesting bound, random sequences
  initial begin
    int unsigned sent;
    stim_row_t   open_row;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) transfer_byte(DirectedRows[i]);
    hold_until_drained();

    // climb to the nesting bound; the opening past it is refused
    open_row = '{ChOpen, 1'b0, 1'b0, 8'h00, 1'b0, ST_PROGRESS};
    repeat (MaxNestingDef + 1) transfer_byte(open_row);

    sent = 0;
    while (sent < 120) begin
      compose_sequence();
      foreach (seq_q[i]) transfer_byte(seq_q[i]);
      sent += seq_q.size();
      if ($urandom_range(0, 15) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
